// ===== rtl/pzs_pkg.sv =====
`default_nettype none
package pzs_pkg;

    localparam int CNT_W     = 16;
    localparam int VAR_W     = 56;
    localparam int SCORE_W   = 11;
    localparam int DIV_W     = 73;
    localparam int DIV_CNT_W = 7;
    localparam int DVS_W     = 32;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int SQ_CNT_W  = 5;

    localparam logic [CNT_W-1:0]   COUNT_MAX     = 16'hFFFF;
    localparam logic [SCORE_W-1:0] SCORE_UNKNOWN = 11'd768;
    localparam logic [SCORE_W-1:0] SCORE_MAX     = 11'd1280;
    localparam logic [SCORE_W-1:0] THRESH_RESET  = 11'd768;
    localparam logic [DVS_W-1:0]   SD_FLOOR      = 32'd256;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_LOAD,
        S_PREP,
        S_DIV_MEAN,
        S_MUL,
        S_SUM,
        S_VSTART,
        S_DIV_VAR,
        S_WRITE,
        S_SQRT,
        S_SSTART,
        S_DIV_SCORE,
        S_EMIT
    } t_back_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

endpackage
`default_nettype wire

// ===== rtl/pzs_in_if.sv =====
`default_nettype none
interface pzs_in_if #(
    parameter int VOLUME_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [7:0]             key_index;
    logic [VOLUME_BITS-1:0] volume;

    modport source (output valid, output action, output key_index, output volume,
                    input ready);
    modport sink   (input valid, input action, input key_index, input volume,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/pzs_out_if.sv =====
`default_nettype none
interface pzs_out_if;
    logic                        valid;
    logic                        ready;
    logic [pzs_pkg::SCORE_W-1:0] score;
    logic                        anomalous;
    logic                        known_key;

    modport source (output valid, output score, output anomalous, output known_key,
                    input ready);
    modport sink   (input valid, input score, input anomalous, input known_key,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/per_key_zscore_anomaly_core.sv =====
// Channel    Direction  Payload
// i_in       sink       action, key_index, volume
// o_out      source     score, anomalous, known_key (score items only)
// i_cfg      write      anomaly_threshold, 11 bits
//
// A train item takes two passes of the shared bit-serial divider, and a score item
// on a trained slot takes the 32-step square root and one divider pass; a score
// item on an untrained slot skips both. After reset a clearing pass writes every
// slot, and no item is accepted until it ends. A two-entry queue between front and
// back and the output register let either side stall alone.
`default_nettype none
module per_key_zscore_anomaly_core #(
    parameter int KEY_SLOTS   = 256,
    parameter int VOLUME_BITS = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [pzs_pkg::SCORE_W-1:0] i_cfg_wdata,
    pzs_in_if.sink                           i_in,
    pzs_out_if.source                        o_out
);
    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int ITEM_W = 1 + SLOT_W + VOLUME_BITS;

    logic [pzs_pkg::SCORE_W-1:0] r_threshold;
    logic                        init_done;
    logic                        q_ready;
    logic                        q_valid;
    logic                        push;
    logic                        pop;
    logic [ITEM_W-1:0]           push_item;
    logic [ITEM_W-1:0]           q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= pzs_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    pzs_front #(
        .KEY_SLOTS   (KEY_SLOTS),
        .VOLUME_BITS (VOLUME_BITS),
        .SLOT_W      (SLOT_W),
        .ITEM_W      (ITEM_W)
    ) u_front (
        .i_in        (i_in),
        .i_init_done (init_done),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_item      (push_item)
    );

    pzs_queue #(
        .W (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    pzs_back #(
        .KEY_SLOTS   (KEY_SLOTS),
        .VOLUME_BITS (VOLUME_BITS),
        .SLOT_W      (SLOT_W),
        .ITEM_W      (ITEM_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_init_done (init_done),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire

// ===== rtl/pzs_queue.sv =====
`default_nettype none
module pzs_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_ready,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/pzs_front.sv =====
`default_nettype none
module pzs_front #(
    parameter int KEY_SLOTS   = 256,
    parameter int VOLUME_BITS = 24,
    parameter int SLOT_W      = 8,
    parameter int ITEM_W      = 33
) (
    pzs_in_if.sink            i_in,
    input  wire logic         i_init_done,
    input  wire logic         i_q_ready,
    output logic              o_push,
    output logic [ITEM_W-1:0] o_item
);
    logic [31:0] slot_red;

    // Reduce the key modulo the slot count by restoring subtraction.
    always_comb begin
        slot_red = {24'd0, i_in.key_index};
        for (int b = 7; b >= 0; b--) begin
            if (slot_red >= (32'(KEY_SLOTS) << b)) begin
                slot_red = slot_red - (32'(KEY_SLOTS) << b);
            end
        end
    end

    assign i_in.ready = i_init_done && i_q_ready;
    assign o_push     = i_in.valid && i_init_done && i_q_ready;
    assign o_item     = {i_in.action, slot_red[SLOT_W-1:0], i_in.volume[VOLUME_BITS-1:0]};
endmodule
`default_nettype wire

// ===== rtl/pzs_div.sv =====
`default_nettype none
module pzs_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pzs_pkg::t_div_req i_req,
    output pzs_pkg::t_div_rsp      o_rsp
);
    logic                            r_busy;
    logic                            r_done;
    logic [pzs_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [pzs_pkg::DVS_W-1:0]       r_rem;
    logic [pzs_pkg::DVS_W-1:0]       r_dvs;
    logic [pzs_pkg::DIV_W-1:0]       r_quo;
    logic [pzs_pkg::DVS_W:0]         rem_sh;
    logic                            fits;

    assign rem_sh = {r_rem, r_quo[pzs_pkg::DIV_W-1]};
    assign fits   = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= fits ? pzs_pkg::DVS_W'(rem_sh - {1'b0, r_dvs})
                          : pzs_pkg::DVS_W'(rem_sh);
            r_quo <= {r_quo[pzs_pkg::DIV_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pzs_pkg::DIV_CNT_W'(pzs_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

// ===== rtl/pzs_sqrt.sv =====
`default_nettype none
module pzs_sqrt (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pzs_pkg::t_sqrt_req i_req,
    output pzs_pkg::t_sqrt_rsp      o_rsp
);
    logic                          r_busy;
    logic                          r_done;
    logic [pzs_pkg::SQ_CNT_W-1:0]  r_cnt;
    logic [pzs_pkg::RAD_W-1:0]     r_rad;
    logic [pzs_pkg::ROOT_W+2:0]    r_rem;
    logic [pzs_pkg::ROOT_W-1:0]    r_root;
    logic [pzs_pkg::ROOT_W+2:0]    rem_sh;
    logic [pzs_pkg::ROOT_W+2:0]    trial;
    logic                          fits;

    // The remainder never exceeds twice the root, so 33 bits plus two shifted in suffice.
    assign rem_sh = {r_rem[pzs_pkg::ROOT_W:0], r_rad[pzs_pkg::RAD_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rad  <= i_req.radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[pzs_pkg::RAD_W-3:0], 2'b00};
            r_rem  <= fits ? rem_sh - trial : rem_sh;
            r_root <= {r_root[pzs_pkg::ROOT_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pzs_pkg::SQ_CNT_W'(pzs_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;
endmodule
`default_nettype wire

// ===== rtl/pzs_back.sv =====
`default_nettype none
module pzs_back #(
    parameter int KEY_SLOTS   = 256,
    parameter int VOLUME_BITS = 24,
    parameter int SLOT_W      = 8,
    parameter int ITEM_W      = 33
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [pzs_pkg::SCORE_W-1:0] i_threshold,
    input  wire logic                        i_q_valid,
    input  wire logic [ITEM_W-1:0]           i_q_item,
    output logic                             o_pop,
    output logic                             o_init_done,
    pzs_out_if.source                        o_out
);
    localparam int MEAN_W = VOLUME_BITS + 16;
    localparam int MUL_CH = (MEAN_W + 15) / 16;
    localparam int E_W    = MUL_CH * 16;
    localparam int PW     = MEAN_W + E_W;
    localparam int ENT_W  = pzs_pkg::CNT_W + MEAN_W + pzs_pkg::VAR_W;

    pzs_pkg::t_back_state r_state, n_state;

    logic [ENT_W-1:0]  r_mem [KEY_SLOTS];
    logic [ENT_W-1:0]  r_rd;
    logic [SLOT_W-1:0] r_clr;
    logic [SLOT_W-1:0] r_slot;
    logic              r_action;
    logic [MEAN_W-1:0] r_x;
    logic [MEAN_W-1:0] r_m;
    logic [pzs_pkg::VAR_W-1:0] r_v;
    logic [pzs_pkg::CNT_W-1:0] r_cnt;
    logic [pzs_pkg::CNT_W-1:0] r_n;
    logic              r_neg;
    logic [MEAN_W-1:0] r_dmag;
    logic [E_W-1:0]    r_emag_sh;
    logic [PW-1:0]     r_prod;
    logic [2:0]        r_chunk;
    logic [pzs_pkg::DIV_W-1:0] r_sum;
    logic [pzs_pkg::DVS_W-1:0] r_sd;
    logic [pzs_pkg::SCORE_W-1:0] r_res_score;
    logic              r_res_known;

    logic                        r_ovalid;
    logic [pzs_pkg::SCORE_W-1:0] r_oscore;
    logic                        r_oanom;
    logic                        r_oknown;

    pzs_pkg::t_div_req  div_req;
    pzs_pkg::t_div_rsp  div_rsp;
    pzs_pkg::t_sqrt_req sq_req;
    pzs_pkg::t_sqrt_rsp sq_rsp;

    logic [pzs_pkg::CNT_W-1:0] rd_cnt;
    logic [MEAN_W-1:0]         rd_mean;
    logic [pzs_pkg::VAR_W-1:0] rd_var;
    logic [MEAN_W-1:0]         step;
    logic [MEAN_W-1:0]         m2;
    logic [71:0]               nv;
    logic                      emit_ok;

    assign rd_cnt  = r_rd[ENT_W-1 -: pzs_pkg::CNT_W];
    assign rd_mean = r_rd[pzs_pkg::VAR_W +: MEAN_W];
    assign rd_var  = r_rd[pzs_pkg::VAR_W-1:0];
    assign step    = div_rsp.quotient[MEAN_W-1:0];
    assign m2      = r_neg ? r_m - step : r_m + step;
    assign nv      = {56'd0, r_n - 16'd1} * {16'd0, r_v};
    assign emit_ok = !r_ovalid || o_out.ready;

    pzs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    pzs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pzs_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_pop             = 1'b0;
        div_req.start     = 1'b0;
        div_req.dividend  = pzs_pkg::DIV_W'(r_dmag);
        div_req.divisor   = {16'd0, r_n};
        sq_req.start      = 1'b0;
        sq_req.radicand   = {r_v, 8'd0};
        unique case (r_state)
            pzs_pkg::S_CLEAR: begin
                if (r_clr == SLOT_W'(KEY_SLOTS - 1)) begin
                    n_state = pzs_pkg::S_IDLE;
                end
            end
            pzs_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = pzs_pkg::S_READ;
                end
            end
            pzs_pkg::S_READ: n_state = pzs_pkg::S_LOAD;
            pzs_pkg::S_LOAD: n_state = pzs_pkg::S_PREP;
            pzs_pkg::S_PREP: begin
                if (!r_action) begin
                    div_req.start = 1'b1;
                    n_state       = pzs_pkg::S_DIV_MEAN;
                end else if (r_cnt == '0) begin
                    n_state = pzs_pkg::S_EMIT;
                end else begin
                    sq_req.start = 1'b1;
                    n_state      = pzs_pkg::S_SQRT;
                end
            end
            pzs_pkg::S_DIV_MEAN: begin
                if (div_rsp.done) begin
                    n_state = pzs_pkg::S_MUL;
                end
            end
            pzs_pkg::S_MUL: begin
                if (r_chunk == 3'(MUL_CH - 1)) begin
                    n_state = pzs_pkg::S_SUM;
                end
            end
            pzs_pkg::S_SUM: n_state = pzs_pkg::S_VSTART;
            pzs_pkg::S_VSTART: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_sum;
                n_state          = pzs_pkg::S_DIV_VAR;
            end
            pzs_pkg::S_DIV_VAR: begin
                if (div_rsp.done) begin
                    n_state = pzs_pkg::S_WRITE;
                end
            end
            pzs_pkg::S_WRITE: n_state = pzs_pkg::S_IDLE;
            pzs_pkg::S_SQRT: begin
                if (sq_rsp.done) begin
                    n_state = pzs_pkg::S_SSTART;
                end
            end
            pzs_pkg::S_SSTART: begin
                div_req.start   = 1'b1;
                div_req.divisor = r_sd;
                n_state         = pzs_pkg::S_DIV_SCORE;
            end
            pzs_pkg::S_DIV_SCORE: begin
                if (div_rsp.done) begin
                    n_state = pzs_pkg::S_EMIT;
                end
            end
            pzs_pkg::S_EMIT: begin
                if (emit_ok) begin
                    n_state = pzs_pkg::S_IDLE;
                end
            end
            default: n_state = pzs_pkg::S_IDLE;
        endcase
    end

    // Slot store: one write port, registered read of the current slot.
    always_ff @(posedge i_clk) begin
        if (r_state == pzs_pkg::S_CLEAR) begin
            r_mem[r_clr] <= '0;
        end else if (r_state == pzs_pkg::S_WRITE) begin
            r_mem[r_slot] <= {r_n, r_m, r_v};
        end
        r_rd <= r_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == pzs_pkg::S_CLEAR) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            pzs_pkg::S_IDLE: begin
                r_action <= i_q_item[ITEM_W-1];
                r_slot   <= i_q_item[VOLUME_BITS +: SLOT_W];
                r_x      <= {i_q_item[VOLUME_BITS-1:0], 16'd0};
            end
            pzs_pkg::S_LOAD: begin
                r_m    <= rd_mean;
                r_v    <= rd_var;
                r_cnt  <= rd_cnt;
                r_n    <= (rd_cnt == pzs_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 16'd1;
                r_neg  <= (r_x < rd_mean);
                r_dmag <= (r_x < rd_mean) ? rd_mean - r_x : r_x - rd_mean;
                r_res_score <= pzs_pkg::SCORE_UNKNOWN;
                r_res_known <= 1'b0;
            end
            pzs_pkg::S_DIV_MEAN: begin
                if (div_rsp.done) begin
                    r_m       <= m2;
                    r_emag_sh <= E_W'(r_dmag - step);
                    r_prod    <= '0;
                    r_chunk   <= '0;
                end
            end
            pzs_pkg::S_MUL: begin
                r_prod    <= (r_prod << 16)
                           + PW'({16'd0, r_dmag} * r_emag_sh[E_W-1 -: 16]);
                r_emag_sh <= r_emag_sh << 16;
                r_chunk   <= r_chunk + 3'd1;
            end
            pzs_pkg::S_SUM: begin
                r_sum <= {1'b0, nv} + pzs_pkg::DIV_W'(r_prod[PW-1:24]);
            end
            pzs_pkg::S_DIV_VAR: begin
                if (div_rsp.done) begin
                    r_v <= (div_rsp.quotient[pzs_pkg::DIV_W-1:pzs_pkg::VAR_W] != '0)
                         ? '1 : div_rsp.quotient[pzs_pkg::VAR_W-1:0];
                end
            end
            pzs_pkg::S_SQRT: begin
                if (sq_rsp.done) begin
                    r_sd <= (sq_rsp.root < pzs_pkg::SD_FLOOR) ? pzs_pkg::SD_FLOOR
                                                               : sq_rsp.root;
                end
            end
            pzs_pkg::S_DIV_SCORE: begin
                if (div_rsp.done) begin
                    r_res_known <= 1'b1;
                    r_res_score <= (div_rsp.quotient > pzs_pkg::DIV_W'(pzs_pkg::SCORE_MAX))
                                 ? pzs_pkg::SCORE_MAX
                                 : div_rsp.quotient[pzs_pkg::SCORE_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // Output register: a finished result waits here while the next item runs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == pzs_pkg::S_EMIT && emit_ok) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pzs_pkg::S_EMIT && emit_ok) begin
            r_oscore <= r_res_score;
            r_oanom  <= (r_res_score >= i_threshold);
            r_oknown <= r_res_known;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.score     = r_oscore;
    assign o_out.anomalous = r_oanom;
    assign o_out.known_key = r_oknown;
    assign o_init_done     = (r_state != pzs_pkg::S_CLEAR);
endmodule
`default_nettype wire
